/* rtl/flp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flp_pkg
// Shared types, constants and coefficient tables of the 17-tap low-pass FIR.
// ----------------------------------------------------------------------------
package flp_pkg;

	localparam int TAP_COUNT  = 17;
	localparam int OUT_WIDTH  = 27;
	localparam int M_TDATA_W  = 32;
	localparam int COEF_WIDTH = 10;
	localparam int BAND_WIDTH = 2;

	typedef enum logic [BAND_WIDTH-1:0] {
		BAND_NARROW = 2'd0,
		BAND_MIDDLE = 2'd1,
		BAND_WIDE   = 2'd2
	} band_t;

	typedef logic signed [COEF_WIDTH-1:0] coef_t;
	typedef coef_t coef_set_t [TAP_COUNT];
	typedef logic signed [OUT_WIDTH-1:0] sum_t;

	localparam coef_set_t COEF_NARROW = '{
		-10'sd7, -10'sd18, -10'sd15, 10'sd11, 10'sd56, 10'sd116, 10'sd177, 10'sd223,
		10'sd240,
		10'sd223, 10'sd177, 10'sd116, 10'sd56, 10'sd11, -10'sd15, -10'sd18, -10'sd7
	};
	localparam coef_set_t COEF_MIDDLE = '{
		10'sd0, -10'sd18, -10'sd38, -10'sd39, 10'sd0, 10'sd83, 10'sd191, 10'sd284,
		10'sd320,
		10'sd284, 10'sd191, 10'sd83, 10'sd0, -10'sd39, -10'sd38, -10'sd18, 10'sd0
	};
	localparam coef_set_t COEF_WIDE = '{
		10'sd6, 10'sd20, 10'sd7, -10'sd42, -10'sd74, -10'sd12, 10'sd159, 10'sd353,
		10'sd440,
		10'sd353, 10'sd159, -10'sd12, -10'sd74, -10'sd42, 10'sd7, 10'sd20, 10'sd6
	};

	// Unused selector code falls back to the wide set.
	function automatic coef_t coef_of(input logic [BAND_WIDTH-1:0] band, input int tap);
		coef_t c;
		case (band)
			BAND_NARROW: c = COEF_NARROW[tap];
			BAND_MIDDLE: c = COEF_MIDDLE[tap];
			default:     c = COEF_WIDE[tap];
		endcase
		return c;
	endfunction

	// Node count after l pairwise reduction levels.
	function automatic int level_count(input int n, input int l);
		int c;
		c = n;
		for (int i = 0; i < l; i++) begin
			c = (c + 1) / 2;
		end
		return c;
	endfunction

	function automatic int tree_levels(input int n);
		int c;
		int lv;
		c  = n;
		lv = 0;
		while (c > 1) begin
			c  = (c + 1) / 2;
			lv = lv + 1;
		end
		return lv;
	endfunction

endpackage
`default_nettype wire

/* rtl/flp_tap_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flp_tap_cell
// One delay-line cell: holds a sample, passes it on, registers its product.
// ----------------------------------------------------------------------------
module flp_tap_cell #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int TAP_INDEX    = 0
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 shift_en,
	input  wire        [flp_pkg::BAND_WIDTH-1:0] band,
	input  wire signed [SAMPLE_WIDTH-1:0]       din,
	output logic signed [SAMPLE_WIDTH-1:0]      tap_q,
	output flp_pkg::sum_t                       prod_s1
);

	localparam int PW = SAMPLE_WIDTH + flp_pkg::COEF_WIDTH;
	localparam int OW = flp_pkg::OUT_WIDTH;

	flp_pkg::coef_t          coef;
	logic signed [PW-1:0]    prod_full;

	assign coef      = flp_pkg::coef_of(band, TAP_INDEX);
	// Multiply the word entering this cell, so the product matches the new window.
	assign prod_full = PW'(din) * PW'(coef);

	// Delay line clears to zero at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (shift_en) begin
			tap_q <= din;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			prod_s1 <= OW'(prod_full);
		end
	end

endmodule
`default_nettype wire

/* rtl/flp_add_tree.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flp_add_tree
// Registered pairwise adder tree with a per-level valid/ready pipeline.
// ----------------------------------------------------------------------------
module flp_add_tree #(
	parameter int N_IN = 17
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  flp_pkg::sum_t  leaf [N_IN],
	output logic           out_valid,
	input  wire            out_ready,
	output flp_pkg::sum_t  out_sum
);

	localparam int LEVELS = flp_pkg::tree_levels(N_IN);

	flp_pkg::sum_t   node [LEVELS+1][N_IN];
	logic [LEVELS:1] v_q;
	logic            rdy [LEVELS+1:1];

	always_comb begin
		rdy[LEVELS+1] = out_ready;
		for (int l = LEVELS; l >= 1; l--) begin
			rdy[l] = !v_q[l] || rdy[l+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[1]) begin
				v_q[1] <= in_valid;
			end
			for (int l = 2; l <= LEVELS; l++) begin
				if (rdy[l]) begin
					v_q[l] <= v_q[l-1];
				end
			end
		end
	end

	genvar gl, gi;
	generate
		for (gi = 0; gi < N_IN; gi++) begin : g_leaf
			assign node[0][gi] = leaf[gi];
		end
		for (gl = 1; gl <= LEVELS; gl++) begin : g_lvl
			localparam int NP = flp_pkg::level_count(N_IN, gl - 1);
			localparam int NC = flp_pkg::level_count(N_IN, gl);
			for (gi = 0; gi < N_IN; gi++) begin : g_node
				if (2 * gi + 1 < NP) begin : g_add
					always_ff @(posedge clk) begin
						if (rdy[gl]) begin
							node[gl][gi] <= node[gl-1][2*gi] + node[gl-1][2*gi+1];
						end
					end
				end else if (gi < NC) begin : g_pass
					// Odd node out: carry it up unchanged.
					always_ff @(posedge clk) begin
						if (rdy[gl]) begin
							node[gl][gi] <= node[gl-1][2*gi];
						end
					end
				end else begin : g_unused
					assign node[gl][gi] = '0;
				end
			end
		end
	endgenerate

	assign in_ready  = rdy[1];
	assign out_valid = v_q[LEVELS];
	assign out_sum   = node[LEVELS][0];

endmodule
`default_nettype wire

/* rtl/fir_lowpass_17tap_three_band_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_lowpass_17tap_three_band_top
// 17-tap low-pass FIR, three selectable coefficient sets, exact integer sum.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one signed sample word per handshake on the s_ channel (s_tdata,
//   low SAMPLE_WIDTH bits). Each accepted word yields exactly one result
//   word on the m_ channel: the full-precision sum of coefficient k times
//   the sample from k words back, wrapped to 27 bits.
//   cfg_we/cfg_wdata write band_select (0 narrow, 1 middle, 2 wide; 3 acts
//   as wide). Write it only while the filter is idle.
// Throughput and pipeline:
//   One word per cycle, sustained while m_tready stays high. The accepting edge
//   loads the registered product stage, which feeds the five registered
//   adder-tree levels in turn; m_tvalid is the valid of the last level.
// Reset:
//   arst_n clears the delay line to zero, drops all stage valids and sets
//   band_select to narrow. No clearing pass; ready right after reset.
// Stall:
//   When m_tready is low, stages fill up behind the held result; s_tready
//   stays high until the product stage would be overwritten, then drops.
// ----------------------------------------------------------------------------
module fir_lowpass_17tap_three_band_top #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// config: band_select
	input  wire                                   cfg_we,
	input  wire  [flp_pkg::BAND_WIDTH-1:0]        cfg_wdata,
	// slave stream; tdata fields from bit 0: sample_in
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	input  wire  [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,
	// master stream; tdata fields from bit 0: filtered_out (27 bits)
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	output logic [flp_pkg::M_TDATA_W-1:0]         m_tdata
);

	localparam int TAPS = flp_pkg::TAP_COUNT;
	localparam int PAD  = flp_pkg::M_TDATA_W - flp_pkg::OUT_WIDTH;

	logic [flp_pkg::BAND_WIDTH-1:0]  band_select_q;
	logic                            prod_v_s1;
	logic                            tree_ready;
	logic                            accept;
	logic signed [SAMPLE_WIDTH-1:0]  sample;
	logic signed [SAMPLE_WIDTH-1:0]  tap [TAPS];
	flp_pkg::sum_t                   prod [TAPS];
	flp_pkg::sum_t                   sum;

	// Config register: hold until written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_select_q <= flp_pkg::BAND_NARROW;
		end else if (cfg_we) begin
			band_select_q <= cfg_wdata;
		end
	end

	assign sample   = $signed(s_tdata[SAMPLE_WIDTH-1:0]);
	// Accept when the product stage is empty or drains into the tree.
	assign s_tready = !prod_v_s1 || tree_ready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s1 <= 1'b0;
		end else if (s_tready) begin
			prod_v_s1 <= s_tvalid;
		end
	end

	// Delay line as a row of cells: each word advances one cell per accept,
	// cell 0 takes the new sample.
	genvar gk;
	generate
		for (gk = 0; gk < TAPS; gk++) begin : g_cell
			flp_tap_cell #(
				.SAMPLE_WIDTH (SAMPLE_WIDTH),
				.TAP_INDEX    (gk)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (accept),
				.band     (band_select_q),
				.din      ((gk == 0) ? sample : tap[(gk == 0) ? 0 : gk - 1]),
				.tap_q    (tap[gk]),
				.prod_s1  (prod[gk])
			);
		end
	endgenerate

	// Sum the seventeen products through the registered tree.
	flp_add_tree #(
		.N_IN (TAPS)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prod_v_s1),
		.in_ready  (tree_ready),
		.leaf      (prod),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_sum   (sum)
	);

	assign m_tdata = {PAD'(0), sum};

endmodule
`default_nettype wire
